@@ design/pts_pkg.sv @@
// Package for the periodic timer scheduler: slot and result types, codes,
// reset values and the saturation and clamp helpers. No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int REM_W   = 26;
    localparam int DELAY_W = 24;
    localparam int TASK_W  = 8;
    localparam int SD_W    = 10;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SD_W-1:0]    SHORT_DEADLINE_RESET = 10'd10;
    localparam logic [DELAY_W-1:0] MAX_INTERVAL_RESET   = 24'd233000;

    localparam logic [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
    localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TASK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPROG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_DEADLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 2'd1;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DELAY_W-1:0] reload;
        logic [TASK_W-1:0]  task_id;
    } slot_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TASK_W-1:0]  event_task;
        logic [DELAY_W-1:0] interval_us;
    } result_t;

    // Per-step control handed to the head unit
    typedef struct packed {
        logic               cmd;
        logic [DELAY_W-1:0] delay_us;
        logic [TASK_W-1:0]  task_id;
        logic [DELAY_W-1:0] interval_now;
        logic [SD_W-1:0]    short_deadline;
        logic               slot_here;
        logic               slot_at_end;
        logic               first_step;
    } head_ctrl_t;

    typedef struct packed {
        logic [REM_W-1:0] best;
        logic             found;
        logic [REM_W-1:0] rem0;
    } head_stat_t;

    function automatic logic [REM_W-1:0] sat_rem(input logic [REM_W:0] v);
        logic [REM_W-1:0] r;
        if (v[REM_W] != v[REM_W-1])
        begin
            r = v[REM_W] ? REM_MIN : REM_MAX;
        end
        else
        begin
            r = v[REM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DELAY_W-1:0] clamp_interval(input logic [REM_W-1:0] v,
                                                          input logic [DELAY_W-1:0] vmax);
        logic [DELAY_W-1:0] r;
        if (v[REM_W-1] || (v == '0))
        begin
            r = '0;
        end
        else if (v[REM_W-2:0] > {1'b0, vmax})
        begin
            r = vmax;
        end
        else
        begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/pts_cell.sv @@
// One slot cell of the timer ring: holds a slot and hands it on each step.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_cell
    import pts_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  slot_t din,
    output slot_t dout
);

    slot_t slot_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            slot_reg <= din;
        end
    end

    assign dout = slot_reg;

endmodule

@@ design/pts_head.sv @@
// Head unit of the timer ring: updates the slot leaving cell 0 on a tick,
// or merges the new timer into the stream on an add. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_head
    import pts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              step_en,
    input  head_ctrl_t        ctrl,
    input  slot_t             din,
    output slot_t             dout,
    output logic              emit,
    output logic [TASK_W-1:0] emit_task,
    output head_stat_t        stat
);

    slot_t            carry_reg;
    slot_t            carry_next;
    logic             ins_reg;
    logic             ins_next;
    logic             found_reg;
    logic             found_next;
    logic [REM_W-1:0] best_reg;
    logic [REM_W-1:0] best_next;
    logic [REM_W-1:0] rem0_reg;
    logic [REM_W-1:0] rem0_next;

    logic [REM_W:0]   diff;
    logic [REM_W-1:0] r1;
    logic [REM_W:0]   sum;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] r;
    logic             expired;
    logic             fits;
    slot_t            new_slot;

    always_comb
    begin
        diff     = {din.rem[REM_W-1], din.rem} - {3'b000, ctrl.interval_now};
        r1       = sat_rem(diff);
        expired  = $signed(r1) <= $signed({{(REM_W-SD_W){1'b0}}, ctrl.short_deadline});
        sum      = {r1[REM_W-1], r1} + {3'b000, din.reload};
        r2       = sat_rem(sum);
        r        = expired ? r2 : r1;

        new_slot.rem     = {2'b00, ctrl.delay_us};
        new_slot.reload  = ctrl.delay_us;
        new_slot.task_id = ctrl.task_id;
        fits = !ins_reg && (ctrl.slot_at_end || (ctrl.slot_here &&
               !($signed({2'b00, ctrl.delay_us}) > $signed(din.rem))));

        dout       = din;
        emit       = 1'b0;
        emit_task  = din.task_id;
        carry_next = carry_reg;
        ins_next   = ins_reg;
        found_next = found_reg;
        best_next  = best_reg;
        rem0_next  = rem0_reg;

        if (ctrl.cmd == CMD_TICK)
        begin
            if (ctrl.slot_here)
            begin
                dout.rem = r;
                emit     = expired;
                if (!r[REM_W-1] && (r != '0) &&
                    (!found_reg || ($signed(r) < $signed(best_reg))))
                begin
                    best_next  = r;
                    found_next = 1'b1;
                end
            end
        end
        else
        begin
            // Insert once, then run every later slot one step late
            if (fits)
            begin
                dout       = new_slot;
                carry_next = din;
                ins_next   = 1'b1;
            end
            else if (ins_reg)
            begin
                dout       = carry_reg;
                carry_next = din;
            end
            if (ctrl.first_step)
            begin
                rem0_next = dout.rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            ins_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (step_en)
        begin
            ins_reg   <= ins_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            carry_reg <= carry_next;
            best_reg  <= best_next;
            rem0_reg  <= rem0_next;
        end
    end

    assign stat.best  = best_reg;
    assign stat.found = found_reg;
    assign stat.rem0  = rem0_reg;

endmodule

@@ design/periodic_timer_scheduler.sv @@
// Periodic timer scheduler top level: control, ring of slot cells, head
// unit and result staging. Depends on pts_pkg, pts_cell and pts_head.
`timescale 1ns / 1ps

// Usage:
//  s_* takes requests: s_tuser is the command (add timer or tick elapsed),
//  s_tdata carries the delay and task id of an add. m_* delivers results:
//  m_tuser is the kind, m_tdata the task id or new interval, m_tlast marks
//  the final result of a request. cfg_* writes the short deadline (index 0)
//  and the interval clamp (index 1); it is always ready.
//  One request is worked at a time. The slots sit in a ring of
//  TIMER_SLOTS cells that rotates once per request through the head unit,
//  one slot per cycle unless a result cannot be held; a full-table add
//  skips the rotation and only reports the full table.
//  Every result passes through a one-deep hold stage so the final one can
//  be marked, then sits in the output register; the next request is taken
//  while that final result waits.
//  A receiver stall halts the ring only when a result must wait; none is lost.
//  Reset empties the table, sets the interval to zero and loads the
//  register defaults; slot contents need no clearing.
module periodic_timer_scheduler
    import pts_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // delay_us[23:0], task_id[31:24]
    input  logic [0:0]           s_tuser,   // cmd[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // event_task[7:0], interval_us[31:8]
    output logic [KIND_W-1:0]    m_tuser,   // kind[1:0]
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(TIMER_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(TIMER_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROT   = 4'b0010,
        S_TAIL  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      step_reg;
    logic [DELAY_W-1:0] interval_reg;
    logic [SD_W-1:0]    sd_reg;
    logic [DELAY_W-1:0] max_reg;
    logic               cmd_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TASK_W-1:0]  task_reg;
    logic               full_reg;

    logic               pend_valid_reg;
    result_t            pend_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               out_last_reg;

    slot_t              ring [TIMER_SLOTS];
    slot_t              head_out;
    logic               head_emit;
    logic [TASK_W-1:0]  head_task;
    head_stat_t         head_stat;
    head_ctrl_t         head_ctrl;

    logic               s_accept;
    logic               out_free;
    logic               can_emit;
    logic               ring_step;
    logic               tail_emit;
    result_t            tail_res;
    logic               tail_go;
    logic               gen_valid;
    result_t            gen_res;
    logic               flush_go;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = !pend_valid_reg || out_free;

    always_comb
    begin
        head_ctrl.cmd            = cmd_reg;
        head_ctrl.delay_us       = delay_reg;
        head_ctrl.task_id        = task_reg;
        head_ctrl.interval_now   = interval_reg;
        head_ctrl.short_deadline = sd_reg;
        head_ctrl.slot_here      = step_reg < count_reg;
        head_ctrl.slot_at_end    = step_reg == count_reg;
        head_ctrl.first_step     = step_reg == '0;
    end

    pts_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_accept),
        .step_en   (ring_step),
        .ctrl      (head_ctrl),
        .din       (ring[0]),
        .dout      (head_out),
        .emit      (head_emit),
        .emit_task (head_task),
        .stat      (head_stat)
    );

    for (genvar k = 0; k < TIMER_SLOTS; k++)
    begin : g_ring
        if (k == TIMER_SLOTS - 1)
        begin : g_tail
            pts_cell u_cell (
                .clk      (clk),
                .shift_en (ring_step),
                .din      (head_out),
                .dout     (ring[k])
            );
        end
        else
        begin : g_mid
            pts_cell u_cell (
                .clk      (clk),
                .shift_en (ring_step),
                .din      (ring[k+1]),
                .dout     (ring[k])
            );
        end
    end

    always_comb
    begin
        tail_res.kind        = KIND_REPROG;
        tail_res.event_task  = '0;
        tail_res.interval_us = '0;
        if (full_reg)
        begin
            tail_emit     = 1'b1;
            tail_res.kind = KIND_FULL;
        end
        else if (cmd_reg == CMD_ADD)
        begin
            tail_emit            = head_stat.rem0 != {2'b00, interval_reg};
            tail_res.interval_us = clamp_interval(head_stat.rem0, max_reg);
        end
        else
        begin
            tail_emit            = head_stat.found;
            tail_res.interval_us = clamp_interval(head_stat.best, max_reg);
        end
    end

    always_comb
    begin
        ring_step  = (state_reg == S_ROT) && (!head_emit || can_emit);
        tail_go    = (state_reg == S_TAIL) && (!tail_emit || can_emit);
        flush_go   = (state_reg == S_FLUSH) && (!pend_valid_reg || out_free);
        gen_valid  = 1'b0;
        gen_res    = tail_res;
        if (state_reg == S_ROT)
        begin
            gen_valid          = ring_step && head_emit;
            gen_res.kind       = KIND_TASK;
            gen_res.event_task = head_task;
            gen_res.interval_us = '0;
        end
        else if (state_reg == S_TAIL)
        begin
            gen_valid = tail_go && tail_emit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if ((s_tuser[0] == CMD_ADD) && (count_reg == FULL_CNT))
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_ROT;
                    end
                end
            end
            S_ROT:
            begin
                if (ring_step && (step_reg == LAST_STEP))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (tail_go)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            interval_reg   <= '0;
            sd_reg         <= SHORT_DEADLINE_RESET;
            max_reg        <= MAX_INTERVAL_RESET;
            full_reg       <= 1'b0;
            cmd_reg        <= CMD_ADD;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SHORT_DEADLINE)
                begin
                    sd_reg <= cfg_data[SD_W-1:0];
                end
                else if (cfg_index == REG_MAX_INTERVAL)
                begin
                    max_reg <= cfg_data;
                end
            end

            if (s_accept)
            begin
                cmd_reg  <= s_tuser[0];
                full_reg <= (s_tuser[0] == CMD_ADD) && (count_reg == FULL_CNT);
                step_reg <= '0;
            end
            else if (ring_step)
            begin
                step_reg <= step_reg + CW'(1);
            end

            if (tail_go && !full_reg)
            begin
                if (tail_emit)
                begin
                    interval_reg <= tail_res.interval_us;
                end
                if (cmd_reg == CMD_ADD)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            // Hand the held result on when a newer one arrives or the request ends
            if ((gen_valid && pend_valid_reg) || (flush_go && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (gen_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_go)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            delay_reg <= s_tdata[DELAY_W-1:0];
            task_reg  <= s_tdata[31:24];
        end
        if (gen_valid)
        begin
            pend_reg <= gen_res;
        end
        if (gen_valid && pend_valid_reg)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b0;
        end
        else if (flush_go && pend_valid_reg)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.interval_us, out_reg.event_task};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("slot count beyond table size");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != S_IDLE))
        else $error("held result left behind at end of request");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_tuser[0] == CMD_ADD) && (count_reg == FULL_CNT))
        |=> (count_reg == $past(count_reg)) && (state_reg == S_TAIL))
        else $error("full-table add altered the table");

endmodule
